/* src/hlts_pkg.sv */
package hlts_pkg;

  localparam int FRAC_BITS   = 16;
  localparam int MAX_HORIZON = 32;

  localparam int SAMPLE_W  = 32;
  localparam int GAIN_W    = FRAC_BITS + 1;
  localparam int HORIZON_W = 6;
  localparam int STATE_W   = 40;
  localparam int WIDE_W    = 48;
  localparam int MULA_W    = GAIN_W + 1;
  localparam int PROD_W    = MULA_W + STATE_W;
  localparam int SHIFT_W   = PROD_W - FRAC_BITS;

  localparam logic [GAIN_W-1:0] GAIN_ONE = GAIN_W'(1) << FRAC_BITS;

  localparam logic [1:0] CFG_ALPHA   = 2'd0;
  localparam logic [1:0] CFG_BETA    = 2'd1;
  localparam logic [1:0] CFG_HORIZON = 2'd2;

  localparam logic [GAIN_W-1:0]    ALPHA_RESET   = GAIN_W'(13107);
  localparam logic [GAIN_W-1:0]    BETA_RESET    = GAIN_W'(13107);
  localparam logic [HORIZON_W-1:0] HORIZON_RESET = HORIZON_W'(5);

  localparam logic signed [WIDE_W-1:0] S40_MAX = 48'sh007F_FFFF_FFFF;
  localparam logic signed [WIDE_W-1:0] S40_MIN = 48'shFF80_0000_0000;
  localparam logic signed [WIDE_W-1:0] S32_MAX = 48'sh0000_7FFF_FFFF;
  localparam logic signed [WIDE_W-1:0] S32_MIN = 48'shFFFF_8000_0000;

  typedef logic signed [SAMPLE_W-1:0] sample_t;
  typedef logic signed [STATE_W-1:0]  state_t;
  typedef logic signed [WIDE_W-1:0]   wide_t;

  typedef enum logic [3:0] {
    OP_NONE,
    OP_SEED_LEVEL,
    OP_SEED_TREND,
    OP_CAPTURE,
    OP_MUL1,
    OP_MUL2,
    OP_MUL3,
    OP_MUL4,
    OP_MUL5,
    OP_MUL6,
    OP_SUM,
    OP_FCAST
  } dp_op_e;

  typedef struct packed {
    dp_op_e op;
    logic   fc;
    logic   last;
  } cmd_t;

  function automatic state_t sat40(input wide_t v);
    state_t r;
    if (v > S40_MAX) begin
      r = S40_MAX[STATE_W-1:0];
    end else if (v < S40_MIN) begin
      r = S40_MIN[STATE_W-1:0];
    end else begin
      r = v[STATE_W-1:0];
    end
    return r;
  endfunction

  function automatic sample_t sat32(input wide_t v);
    sample_t r;
    if (v > S32_MAX) begin
      r = S32_MAX[SAMPLE_W-1:0];
    end else if (v < S32_MIN) begin
      r = S32_MIN[SAMPLE_W-1:0];
    end else begin
      r = v[SAMPLE_W-1:0];
    end
    return r;
  endfunction

endpackage

/* src/hlts_in_if.sv */
interface hlts_in_if;
  import hlts_pkg::*;

  logic    valid;
  logic    ready;
  sample_t sample_value;
  logic    end_of_series;

  modport source(output valid, output sample_value, output end_of_series, input ready);
  modport sink(input valid, input sample_value, input end_of_series, output ready);
endinterface

/* src/hlts_out_if.sv */
interface hlts_out_if;
  import hlts_pkg::*;

  logic    valid;
  logic    ready;
  sample_t smoothed_value;
  logic    is_forecast;
  logic    run_last;

  modport source(output valid, output smoothed_value, output is_forecast, output run_last,
                 input ready);
  modport sink(input valid, input smoothed_value, input is_forecast, input run_last,
               output ready);
endinterface

/* src/hlts_dp.sv */
module hlts_dp (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  hlts_pkg::cmd_t                    cmd_i,
  input  hlts_pkg::sample_t                 sample_i,
  input  logic [hlts_pkg::GAIN_W-1:0]       alpha_i,
  input  logic [hlts_pkg::GAIN_W-1:0]       beta_i,
  output hlts_pkg::sample_t                 value_o,
  output logic                              fc_o,
  output logic                              last_o
);
  import hlts_pkg::*;

  state_t                    level_q, trend_q;
  state_t                    s_q, lv_q, d_q;
  sample_t                   x_q;
  wide_t                     acc_q;
  logic                      fc_q, last_q;
  logic signed [PROD_W-1:0]  prod_q;
  logic signed [SHIFT_W-1:0] t_q;

  logic [GAIN_W-1:0]         alpha_eff, beta_eff, alpha_rem, beta_rem;
  logic signed [MULA_W-1:0]  mul_a;
  state_t                    mul_b;
  logic signed [SHIFT_W-1:0] prod_sh;
  wide_t                     upd_sum;

  assign alpha_eff = (alpha_i > GAIN_ONE) ? GAIN_ONE : alpha_i;
  assign beta_eff  = (beta_i > GAIN_ONE) ? GAIN_ONE : beta_i;
  assign alpha_rem = GAIN_ONE - alpha_eff;
  assign beta_rem  = GAIN_ONE - beta_eff;

  assign prod_sh = $signed(prod_q[PROD_W-1:FRAC_BITS]);
  assign upd_sum = WIDE_W'(t_q) + WIDE_W'(prod_sh);

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (cmd_i.op)
      OP_MUL1: begin
        mul_a = $signed({1'b0, alpha_eff});
        mul_b = STATE_W'(x_q);
      end
      OP_MUL2: begin
        mul_a = $signed({1'b0, alpha_rem});
        mul_b = s_q;
      end
      OP_MUL3: begin
        mul_a = $signed({1'b0, beta_rem});
        mul_b = trend_q;
      end
      OP_MUL5: begin
        mul_a = $signed({1'b0, beta_eff});
        mul_b = d_q;
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      level_q <= '0;
      trend_q <= '0;
    end else begin
      case (cmd_i.op)
        OP_SEED_LEVEL: begin
          level_q <= STATE_W'(sample_i);
          trend_q <= '0;
        end
        OP_SEED_TREND: trend_q <= sat40(WIDE_W'(sample_i) - WIDE_W'(level_q));
        OP_MUL4:       level_q <= lv_q;
        OP_MUL6:       trend_q <= sat40(upd_sum);
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    prod_q <= mul_a * mul_b;
    case (cmd_i.op)
      OP_SEED_LEVEL: begin
        acc_q  <= WIDE_W'(sample_i);
        fc_q   <= cmd_i.fc;
        last_q <= cmd_i.last;
      end
      OP_SEED_TREND: x_q <= sample_i;
      OP_CAPTURE:    x_q <= sample_i;
      OP_MUL1:       s_q <= sat40(WIDE_W'(level_q) + WIDE_W'(trend_q));
      OP_MUL2:       t_q <= prod_sh;
      OP_MUL3:       lv_q <= sat40(upd_sum);
      OP_MUL4: begin
        t_q <= prod_sh;
        d_q <= sat40(WIDE_W'(lv_q) - WIDE_W'(level_q));
      end
      OP_SUM: begin
        acc_q  <= WIDE_W'(level_q) + WIDE_W'(trend_q);
        fc_q   <= cmd_i.fc;
        last_q <= cmd_i.last;
      end
      OP_FCAST: begin
        acc_q  <= acc_q + WIDE_W'(trend_q);
        fc_q   <= cmd_i.fc;
        last_q <= cmd_i.last;
      end
      default: ;
    endcase
  end

  assign value_o = sat32(acc_q);
  assign fc_o    = fc_q;
  assign last_o  = last_q;

endmodule

/* src/hlts_ctrl.sv */
module hlts_ctrl (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  input  logic                              in_eos_i,
  output logic                              in_ready_o,
  output logic                              out_valid_o,
  input  logic                              out_ready_i,
  input  logic [hlts_pkg::HORIZON_W-1:0]    horizon_i,
  output hlts_pkg::cmd_t                    cmd_o
);
  import hlts_pkg::*;

  localparam logic [3:0] ST_IDLE  = 4'd0;
  localparam logic [3:0] ST_LOAD  = 4'd1;
  localparam logic [3:0] ST_M1    = 4'd2;
  localparam logic [3:0] ST_M2    = 4'd3;
  localparam logic [3:0] ST_M3    = 4'd4;
  localparam logic [3:0] ST_M4    = 4'd5;
  localparam logic [3:0] ST_M5    = 4'd6;
  localparam logic [3:0] ST_M6    = 4'd7;
  localparam logic [3:0] ST_EMIT  = 4'd8;
  localparam logic [3:0] ST_FCAST = 4'd9;
  localparam logic [3:0] ST_OUT   = 4'd10;

  localparam logic [1:0] PH_FIRST  = 2'd0;
  localparam logic [1:0] PH_SECOND = 2'd1;
  localparam logic [1:0] PH_RUN    = 2'd2;

  logic [3:0]           state_q, state_d, ret_q, ret_d;
  logic [1:0]           phase_q, phase_d;
  logic                 eos_q, eos_d;
  logic [HORIZON_W-1:0] k_q, k_d, h_eff;
  logic                 fcast_more, fcast_last;

  assign h_eff = (horizon_i == '0) ? HORIZON_W'(1) :
                 (horizon_i > HORIZON_W'(MAX_HORIZON)) ? HORIZON_W'(MAX_HORIZON) : horizon_i;
  assign fcast_more = eos_q && (h_eff > HORIZON_W'(1));
  assign fcast_last = (k_q >= h_eff);

  assign in_ready_o  = (state_q == ST_IDLE);
  assign out_valid_o = (state_q == ST_OUT);

  always_comb begin
    state_d = state_q;
    ret_d   = ret_q;
    phase_d = phase_q;
    eos_d   = eos_q;
    k_d     = k_q;
    cmd_o   = '{op: OP_NONE, fc: 1'b0, last: 1'b0};
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          eos_d = in_eos_i;
          case (phase_q)
            PH_FIRST: begin
              cmd_o   = '{op: OP_SEED_LEVEL, fc: 1'b0, last: 1'b1};
              ret_d   = ST_IDLE;
              state_d = ST_OUT;
              phase_d = in_eos_i ? PH_FIRST : PH_SECOND;
            end
            PH_SECOND: begin
              cmd_o.op = OP_SEED_TREND;
              state_d  = ST_LOAD;
              phase_d  = in_eos_i ? PH_FIRST : PH_RUN;
            end
            default: begin
              cmd_o.op = OP_CAPTURE;
              state_d  = ST_M1;
              phase_d  = in_eos_i ? PH_FIRST : PH_RUN;
            end
          endcase
        end
      end
      ST_LOAD: begin
        cmd_o   = '{op: OP_SUM, fc: 1'b0, last: 1'b0};
        ret_d   = ST_M1;
        state_d = ST_OUT;
      end
      ST_M1: begin
        cmd_o.op = OP_MUL1;
        state_d  = ST_M2;
      end
      ST_M2: begin
        cmd_o.op = OP_MUL2;
        state_d  = ST_M3;
      end
      ST_M3: begin
        cmd_o.op = OP_MUL3;
        state_d  = ST_M4;
      end
      ST_M4: begin
        cmd_o.op = OP_MUL4;
        state_d  = ST_M5;
      end
      ST_M5: begin
        cmd_o.op = OP_MUL5;
        state_d  = ST_M6;
      end
      ST_M6: begin
        cmd_o.op = OP_MUL6;
        state_d  = ST_EMIT;
      end
      ST_EMIT: begin
        cmd_o   = '{op: OP_SUM, fc: eos_q, last: !fcast_more};
        ret_d   = fcast_more ? ST_FCAST : ST_IDLE;
        k_d     = HORIZON_W'(2);
        state_d = ST_OUT;
      end
      ST_FCAST: begin
        cmd_o   = '{op: OP_FCAST, fc: 1'b1, last: fcast_last};
        ret_d   = fcast_last ? ST_IDLE : ST_FCAST;
        k_d     = k_q + HORIZON_W'(1);
        state_d = ST_OUT;
      end
      ST_OUT: begin
        if (out_ready_i) begin
          state_d = ret_q;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      ret_q   <= ST_IDLE;
      phase_q <= PH_FIRST;
      eos_q   <= 1'b0;
      k_q     <= '0;
    end else begin
      state_q <= state_d;
      ret_q   <= ret_d;
      phase_q <= phase_d;
      eos_q   <= eos_d;
      k_q     <= k_d;
    end
  end

  a_no_overlap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(in_ready_o && out_valid_o))
    else $error("input and output handshakes open together");

  a_accept_leaves_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> (state_q != ST_IDLE))
    else $error("accepted sample did not start work");

  a_fcast_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_FCAST) |-> (k_q >= HORIZON_W'(2) && k_q <= h_eff))
    else $error("forecast step out of range");

  a_fcast_needs_eos: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_FCAST) |-> (eos_q && phase_q == PH_FIRST))
    else $error("forecast outside series end");

endmodule

/* src/holt_linear_trend_smoother.sv */
// Holt linear trend smoother, Q16.16 samples, Q1.16 gains.
// sample_i: one sample per transfer, end_of_series on the last of a series.
// result_o: smoothed or forecast values; run_last marks the final result of a sample.
// cfg_*: write alpha (0), beta (1) and horizon (2) only while the block is idle.
// One shared 18x40 multiplier runs the level and trend update as a six-step chain,
// after which the smoothed result is emitted; the second sample of a series first
// yields the seeded level plus trend, a first sample its own value. Each forecast
// value adds the trend to the previous result.
// The block takes no new sample while any result of the current one is pending.
// A stalled receiver holds the current result steady and freezes the sequence.
// Reset clears level, trend and phase and loads the default gains and horizon.
module holt_linear_trend_smoother (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  hlts_in_if.sink                       sample_i,
  hlts_out_if.source                    result_o,
  input  logic                          cfg_we_i,
  input  logic [1:0]                    cfg_idx_i,
  input  logic [hlts_pkg::GAIN_W-1:0]   cfg_data_i
);
  import hlts_pkg::*;

  logic [GAIN_W-1:0]    alpha_q, beta_q;
  logic [HORIZON_W-1:0] horizon_q;
  cmd_t                 cmd;
  logic                 in_ready, out_valid;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      alpha_q   <= ALPHA_RESET;
      beta_q    <= BETA_RESET;
      horizon_q <= HORIZON_RESET;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_ALPHA:   alpha_q   <= cfg_data_i;
        CFG_BETA:    beta_q    <= cfg_data_i;
        CFG_HORIZON: horizon_q <= cfg_data_i[HORIZON_W-1:0];
        default: ;
      endcase
    end
  end

  hlts_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (sample_i.valid),
    .in_eos_i    (sample_i.end_of_series),
    .in_ready_o  (in_ready),
    .out_valid_o (out_valid),
    .out_ready_i (result_o.ready),
    .horizon_i   (horizon_q),
    .cmd_o       (cmd)
  );

  hlts_dp u_dp (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .cmd_i    (cmd),
    .sample_i (sample_i.sample_value),
    .alpha_i  (alpha_q),
    .beta_i   (beta_q),
    .value_o  (result_o.smoothed_value),
    .fc_o     (result_o.is_forecast),
    .last_o   (result_o.run_last)
  );

  assign sample_i.ready = in_ready;
  assign result_o.valid = out_valid;

endmodule
